[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/occ_pkg.sv]
// ----------------------------------------------------------------------------
// occ_pkg
// Shared constants and lane status type for the order crossover block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

    localparam int CUT_START_W = 5;
    localparam int CUT_END_W   = 6;
    localparam int DRAW_W      = 16;
    localparam int THRESH_W    = 17;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'h10000;

    typedef struct packed {
        logic busy;
        logic valid;
        logic last;
    } t_lane_status;

endpackage

`default_nettype wire

[hdl/occ_lane.sv]
// ----------------------------------------------------------------------------
// occ_lane
// One child builder: parent memory, child compare bank, cyclic fill scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module occ_lane #(
    parameter int MAX_GENES  = 32,
    parameter int GENE_WIDTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_load_we,
    input  wire  [$clog2(MAX_GENES)-1:0]         i_load_addr,
    input  wire  [GENE_WIDTH-1:0]                i_load_gene,
    input  wire                                  i_start,
    input  wire  [$clog2(MAX_GENES+1)-1:0]       i_n,
    input  wire  [$clog2(MAX_GENES+1)-1:0]       i_a,
    input  wire  [$clog2(MAX_GENES+1)-1:0]       i_b,
    input  wire                                  i_xover,
    output occ_pkg::t_lane_status                o_status,
    output logic [GENE_WIDTH-1:0]                o_gene,
    input  wire                                  i_take
);
    import occ_pkg::*;

    localparam int IDX_W = $clog2(MAX_GENES);
    localparam int CNT_W = $clog2(MAX_GENES+1);
    localparam logic [GENE_WIDTH-1:0] SEPARATOR = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_READ,
        S_TEST,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_i, n_i;
    logic [IDX_W-1:0]       r_p, n_p;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic [CNT_W-1:0]       r_steps, n_steps;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [CNT_W-1:0]       r_a, n_a;
    logic [CNT_W-1:0]       r_b, n_b;
    logic                   r_xover, n_xover;
    logic                   r_copy, n_copy;
    logic [MAX_GENES-1:0]   r_filled, n_filled;
    logic [GENE_WIDTH-1:0]  r_cand, n_cand;
    logic [GENE_WIDTH-1:0]  r_result, n_result;

    logic [GENE_WIDTH-1:0]  r_mem [MAX_GENES];
    logic [GENE_WIDTH-1:0]  r_child [MAX_GENES];
    logic [GENE_WIDTH-1:0]  r_rd_data;
    logic [MAX_GENES-1:0]   r_hit;

    logic [CNT_W-1:0]       w_i_ext;
    logic [CNT_W-1:0]       w_i_inc;
    logic [CNT_W-1:0]       w_p_inc;
    logic [IDX_W-1:0]       w_p_next;
    logic                   w_inseg;
    logic                   w_copy;
    logic                   w_take;
    logic                   w_last;
    logic                   w_fill;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;

    assign w_i_ext  = CNT_W'(r_i);
    assign w_i_inc  = w_i_ext + CNT_W'(1);
    assign w_p_inc  = CNT_W'(r_p) + CNT_W'(1);
    assign w_p_next = (w_p_inc == r_n) ? '0 : w_p_inc[IDX_W-1:0];
    assign w_inseg  = (w_i_ext >= r_a) && (w_i_ext < r_b);
    assign w_copy   = !r_xover || w_inseg;
    assign w_take   = (r_steps == r_n) || (r_cand == SEPARATOR) || !(|r_hit);
    assign w_last   = (w_i_inc == r_n);
    assign w_fill   = (r_state == S_TEST) && w_take;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_pos;
        case (r_state)
            S_POS: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_copy ? r_i : r_pos;
            end
            S_TEST: begin
                w_rd_en   = !w_take;
                w_rd_addr = w_p_next;
            end
            default: begin
                w_rd_en   = 1'b0;
                w_rd_addr = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load_we) begin
            r_mem[i_load_addr] <= i_load_gene;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_we) begin
            r_child[i_load_addr] <= i_load_gene;
        end else if (w_fill) begin
            r_child[r_i] <= r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            for (int j = 0; j < MAX_GENES; j++) begin
                r_hit[j] <= r_filled[j] && (r_child[j] == r_rd_data);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_p      = r_p;
        n_pos    = r_pos;
        n_steps  = r_steps;
        n_n      = r_n;
        n_a      = r_a;
        n_b      = r_b;
        n_xover  = r_xover;
        n_copy   = r_copy;
        n_filled = r_filled;
        n_cand   = r_cand;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_a     = i_a;
                    n_b     = i_b;
                    n_xover = i_xover;
                    n_i     = '0;
                    n_steps = '0;
                    n_pos   = (i_b == i_n) ? '0 : i_b[IDX_W-1:0];
                    for (int j = 0; j < MAX_GENES; j++) begin
                        n_filled[j] = i_xover && (CNT_W'(j) >= i_a) && (CNT_W'(j) < i_b);
                    end
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_copy  = w_copy;
                n_p     = r_pos;
                n_steps = '0;
                n_state = S_READ;
            end
            S_READ: begin
                if (r_copy) begin
                    n_result = r_rd_data;
                    n_state  = S_EMIT;
                end else begin
                    n_cand  = r_rd_data;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (w_take) begin
                    n_result      = r_cand;
                    n_filled[r_i] = 1'b1;
                    n_pos         = w_p_next;
                    n_state       = S_EMIT;
                end else begin
                    n_p     = w_p_next;
                    n_steps = r_steps + CNT_W'(1);
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (i_take) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = S_POS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_p      <= '0;
            r_pos    <= '0;
            r_steps  <= '0;
            r_n      <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_xover  <= 1'b0;
            r_copy   <= 1'b0;
            r_filled <= '0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_p      <= n_p;
            r_pos    <= n_pos;
            r_steps  <= n_steps;
            r_n      <= n_n;
            r_a      <= n_a;
            r_b      <= n_b;
            r_xover  <= n_xover;
            r_copy   <= n_copy;
            r_filled <= n_filled;
        end
        r_cand   <= n_cand;
        r_result <= n_result;
    end

    assign o_status.busy  = (r_state != S_IDLE);
    assign o_status.valid = (r_state == S_EMIT);
    assign o_status.last  = w_last;
    assign o_gene         = r_result;

    `ASSERT_IMPLY(a_steps_bound, i_clk, i_rst_n, r_state != S_IDLE, r_steps <= r_n)
    `ASSERT_IMPLY(a_emit_in_range, i_clk, i_rst_n, r_state == S_EMIT, w_i_ext < r_n)
    `ASSERT_IMPLY(a_fill_marked, i_clk, i_rst_n, (r_state == S_EMIT) && !r_copy, r_filled[r_i])

endmodule

`default_nettype wire

[hdl/occ_merge.sv]
// ----------------------------------------------------------------------------
// occ_merge
// Pair the two lane results into one output word behind a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module occ_merge #(
    parameter int GENE_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  occ_pkg::t_lane_status       i_stat_a,
    input  occ_pkg::t_lane_status       i_stat_b,
    input  wire  [GENE_WIDTH-1:0]       i_gene_a,
    input  wire  [GENE_WIDTH-1:0]       i_gene_b,
    output logic                        o_take,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [GENE_WIDTH-1:0]       o_first_child_gene,
    output logic [GENE_WIDTH-1:0]       o_second_child_gene,
    output logic                        o_final_gene
);
    import occ_pkg::*;

    logic                   r_valid;
    logic [GENE_WIDTH-1:0]  r_first;
    logic [GENE_WIDTH-1:0]  r_second;
    logic                   r_final;

    assign o_take = i_stat_a.valid && i_stat_b.valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_take) begin
            r_first  <= i_gene_a;
            r_second <= i_gene_b;
            r_final  <= i_stat_a.last;
        end
    end

    assign o_valid             = r_valid;
    assign o_first_child_gene  = r_first;
    assign o_second_child_gene = r_second;
    assign o_final_gene        = r_final;

    `ASSERT_IMPLY(a_lanes_aligned, i_clk, i_rst_n, i_stat_a.valid && i_stat_b.valid, i_stat_a.last == i_stat_b.last)

endmodule

`default_nettype wire

[hdl/order_crossover_with_separators_top.sv]
// ----------------------------------------------------------------------------
// order_crossover_with_separators_top
// Order crossover of two parent gene sequences with a repeatable separator.
// ----------------------------------------------------------------------------
// Parents load one word per cycle, one gene of each parent per word; the word
// marked last starts the crossover and the input stalls until both children
// are built. Each child has its own lane. A position copied from the parent
// passes the position, read and emit states; a filled position adds a test
// state, and the cyclic scan repeats read and test for each rejected gene,
// one parent memory read and one child bank compare per candidate. The lanes
// advance in step, so the slower lane sets the pace of each output word.
// Config writes to the threshold take effect on the next last word.
`timescale 1ns / 1ps
`default_nettype none

module order_crossover_with_separators_top #(
    parameter int MAX_GENES  = 32,
    parameter int GENE_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [GENE_WIDTH-1:0]               i_first_gene,
    input  wire  [GENE_WIDTH-1:0]               i_second_gene,
    input  wire                                 i_last_gene,
    input  wire  [occ_pkg::DRAW_W-1:0]          i_random_draw,
    input  wire  [occ_pkg::CUT_START_W-1:0]     i_cut_start,
    input  wire  [occ_pkg::CUT_END_W-1:0]       i_cut_end,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [GENE_WIDTH-1:0]               o_first_child_gene,
    output logic [GENE_WIDTH-1:0]               o_second_child_gene,
    output logic                                o_final_gene,
    input  wire                                 i_cfg_wr_en,
    input  wire  [occ_pkg::THRESH_W-1:0]        i_cfg_wr_data
);
    import occ_pkg::*;

    localparam int IDX_W = $clog2(MAX_GENES);
    localparam int CNT_W = $clog2(MAX_GENES+1);
    localparam int CW    = (CNT_W > CUT_END_W) ? CNT_W : CUT_END_W;

    logic [THRESH_W-1:0]    r_threshold;
    logic [CNT_W-1:0]       r_count;
    logic                   r_start;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_a;
    logic [CNT_W-1:0]       r_b;
    logic                   r_xover;

    t_lane_status           w_stat_a;
    t_lane_status           w_stat_b;
    logic [GENE_WIDTH-1:0]  w_gene_a;
    logic [GENE_WIDTH-1:0]  w_gene_b;
    logic [GENE_WIDTH-1:0]  w_first_gene;
    logic [GENE_WIDTH-1:0]  w_second_gene;
    logic                   w_take;

    logic                   w_accept;
    logic                   w_room;
    logic                   w_load_we;
    logic [CNT_W-1:0]       w_count_next;
    logic [CW-1:0]          w_n_cw;
    logic [CW-1:0]          w_b_cw;
    logic [CW-1:0]          w_a_cw;

    assign o_ready      = !r_start && !w_stat_a.busy && !w_stat_b.busy;
    assign w_accept     = i_valid && o_ready;
    assign w_room       = (r_count < CNT_W'(MAX_GENES));
    assign w_load_we    = w_accept && w_room;
    assign w_count_next = w_room ? (r_count + CNT_W'(1)) : r_count;

    assign w_n_cw = CW'(w_count_next);
    assign w_b_cw = (CW'(i_cut_end) > w_n_cw) ? w_n_cw : CW'(i_cut_end);
    assign w_a_cw = (CW'(i_cut_start) > w_b_cw) ? w_b_cw : CW'(i_cut_start);

    // without crossover each lane copies the other parent, so swap them back
    assign w_first_gene  = r_xover ? w_gene_a : w_gene_b;
    assign w_second_gene = r_xover ? w_gene_b : w_gene_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_count     <= '0;
            r_start     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            r_start <= 1'b0;
            if (w_accept) begin
                if (i_last_gene) begin
                    r_count <= '0;
                    r_start <= 1'b1;
                end else begin
                    r_count <= w_count_next;
                end
            end
        end
        if (w_accept && i_last_gene) begin
            r_n     <= w_count_next;
            r_b     <= w_b_cw[CNT_W-1:0];
            r_a     <= w_a_cw[CNT_W-1:0];
            r_xover <= (THRESH_W'(i_random_draw) < r_threshold);
        end
    end

    occ_lane #(
        .MAX_GENES  (MAX_GENES),
        .GENE_WIDTH (GENE_WIDTH)
    ) u_lane_first (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_we   (w_load_we),
        .i_load_addr (r_count[IDX_W-1:0]),
        .i_load_gene (i_second_gene),
        .i_start     (r_start),
        .i_n         (r_n),
        .i_a         (r_a),
        .i_b         (r_b),
        .i_xover     (r_xover),
        .o_status    (w_stat_a),
        .o_gene      (w_gene_a),
        .i_take      (w_take)
    );

    occ_lane #(
        .MAX_GENES  (MAX_GENES),
        .GENE_WIDTH (GENE_WIDTH)
    ) u_lane_second (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_we   (w_load_we),
        .i_load_addr (r_count[IDX_W-1:0]),
        .i_load_gene (i_first_gene),
        .i_start     (r_start),
        .i_n         (r_n),
        .i_a         (r_a),
        .i_b         (r_b),
        .i_xover     (r_xover),
        .o_status    (w_stat_b),
        .o_gene      (w_gene_b),
        .i_take      (w_take)
    );

    occ_merge #(
        .GENE_WIDTH (GENE_WIDTH)
    ) u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_stat_a            (w_stat_a),
        .i_stat_b            (w_stat_b),
        .i_gene_a            (w_first_gene),
        .i_gene_b            (w_second_gene),
        .o_take              (w_take),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_first_child_gene  (o_first_child_gene),
        .o_second_child_gene (o_second_child_gene),
        .o_final_gene        (o_final_gene)
    );

endmodule

`default_nettype wire
